// ===== src/kfc_pkg.sv =====
// ----------------------------------------------------------------------------
// kfc_pkg
// Shared types and constants of the keypad four-function calculator.
// ----------------------------------------------------------------------------
package kfc_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int VALUE_WIDTH   = 16;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

   typedef logic [OPERAND_WIDTH-1:0] operand_type;
   typedef logic [VALUE_WIDTH-1:0]   value_type;
   typedef logic [CNT_WIDTH-1:0]     count_type;

   localparam logic [2:0] KIND_DIGIT  = 3'd0;
   localparam logic [2:0] KIND_ADD    = 3'd1;
   localparam logic [2:0] KIND_SUB    = 3'd2;
   localparam logic [2:0] KIND_MUL    = 3'd3;
   localparam logic [2:0] KIND_DIV    = 3'd4;
   localparam logic [2:0] KIND_EQUALS = 3'd5;
   localparam logic [2:0] KIND_CLEAR  = 3'd6;

   localparam logic [2:0] OP_NONE = 3'd0;

   localparam logic [1:0] STATUS_POS  = 2'd0;
   localparam logic [1:0] STATUS_NEG  = 2'd1;
   localparam logic [1:0] STATUS_DIV0 = 2'd2;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_DONE   = 2'd2;

   localparam operand_type TEN = operand_type'(10);

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] digit;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      value_type  value;
   } rsp_word_type;

   typedef struct packed {
      logic start;
      logic op_div;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

endpackage

// ===== src/keypad_four_function_calculator_unit.sv =====
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_unit
// Keypad calculator: operand entry, operator sequencing and result delivery.
// ----------------------------------------------------------------------------
//  port group | dir | handshake             | word
//  req_       | in  | req_valid/req_ready   | kind, digit
//  rsp_       | out | rsp_valid/rsp_ready   | status, value
//
//  A digit in phase 0 or 1 runs in the serial ALU (S_ACC), and a multiply or
//  divide result runs there too (S_CALC); the unit takes the next key only
//  once it is back in S_IDLE. Clear and unused codes stay in S_IDLE, other
//  keys pass through S_EVAL, and a result goes on through S_EMIT. Reset and
//  clear zero the operands, operator, equals flag and phase; a waiting result
//  stalls the unit only once the next result is ready.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kfc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kfc_pkg::rsp_word_type rsp_word
);

   localparam int W = kfc_pkg::OPERAND_WIDTH;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_ACC  = 5'b00010,
      S_EVAL = 5'b00100,
      S_CALC = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   kfc_pkg::operand_type  first_ff, first_in;
   kfc_pkg::operand_type  second_ff, second_in;
   logic [2:0]            op_ff, op_in;
   logic                  eq_ff, eq_in;
   logic [1:0]            phase_ff, phase_in;
   logic [1:0]            res_status_ff, res_status_in;
   kfc_pkg::operand_type  res_value_ff, res_value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   kfc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   kfc_pkg::alu_cmd_type  alu_cmd;
   kfc_pkg::alu_sts_type  alu_sts;
   kfc_pkg::operand_type  alu_a, alu_b, alu_addend, alu_result;

   logic                  req_take;
   logic [W:0]            diff;
   logic                  a_gt_b;

   kfc_serial_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .a      (alu_a),
      .b      (alu_b),
      .addend (alu_addend),
      .sts    (alu_sts),
      .result (alu_result)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign diff      = {1'b0, first_ff} - {1'b0, second_ff};
   assign a_gt_b    = !diff[W] && (diff[W-1:0] != '0);

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      op_in         = op_ff;
      eq_in         = eq_ff;
      phase_in      = phase_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_word_in   = rsp_word_ff;
      alu_cmd       = '0;
      alu_a         = first_ff;
      alu_b         = second_ff;
      alu_addend    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_word.kind)
                  kfc_pkg::KIND_DIGIT: begin
                     if (phase_ff == kfc_pkg::PHASE_DONE) begin
                        state_in = S_EVAL;
                     end else begin
                        alu_cmd.start = 1'b1;
                        alu_a         = (phase_ff == kfc_pkg::PHASE_FIRST) ? first_ff
                                                                          : second_ff;
                        alu_b         = kfc_pkg::TEN;
                        alu_addend    = kfc_pkg::operand_type'(req_word.digit);
                        state_in      = S_ACC;
                     end
                  end
                  kfc_pkg::KIND_ADD, kfc_pkg::KIND_SUB,
                  kfc_pkg::KIND_MUL, kfc_pkg::KIND_DIV,
                  kfc_pkg::KIND_EQUALS: begin
                     if (req_word.kind == kfc_pkg::KIND_EQUALS) begin
                        eq_in = 1'b1;
                     end else begin
                        op_in = req_word.kind;
                     end
                     if (phase_ff != kfc_pkg::PHASE_DONE) begin
                        phase_in = phase_ff + 2'd1;
                     end
                     state_in = S_EVAL;
                  end
                  kfc_pkg::KIND_CLEAR: begin
                     first_in  = '0;
                     second_in = '0;
                     op_in     = kfc_pkg::OP_NONE;
                     eq_in     = 1'b0;
                     phase_in  = kfc_pkg::PHASE_FIRST;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ACC: begin
            if (alu_sts.done) begin
               if (phase_ff == kfc_pkg::PHASE_FIRST) begin
                  first_in = alu_result;
               end else begin
                  second_in = alu_result;
               end
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!eq_ff || phase_ff == kfc_pkg::PHASE_FIRST || op_ff == kfc_pkg::OP_NONE) begin
               state_in = S_IDLE;
            end else begin
               res_status_in = kfc_pkg::STATUS_POS;
               state_in      = S_EMIT;
               case (op_ff)
                  kfc_pkg::KIND_ADD: begin
                     res_value_in = first_ff + second_ff;
                  end
                  kfc_pkg::KIND_SUB: begin
                     if (a_gt_b) begin
                        res_value_in = diff[W-1:0];
                     end else begin
                        res_status_in = kfc_pkg::STATUS_NEG;
                        res_value_in  = ~diff[W-1:0] + kfc_pkg::operand_type'(1);
                     end
                  end
                  kfc_pkg::KIND_MUL: begin
                     alu_cmd.start = 1'b1;
                     state_in      = S_CALC;
                  end
                  default: begin
                     if (second_ff == '0) begin
                        res_status_in = kfc_pkg::STATUS_DIV0;
                        res_value_in  = '0;
                     end else begin
                        alu_cmd.start  = 1'b1;
                        alu_cmd.op_div = 1'b1;
                        state_in       = S_CALC;
                     end
                  end
               endcase
            end
         end
         S_CALC: begin
            if (alu_sts.done) begin
               res_value_in = alu_result;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_word_in.status = res_status_ff;
               rsp_word_in.value  = kfc_pkg::value_type'(res_value_ff);
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= '0;
         second_ff    <= '0;
         op_ff        <= kfc_pkg::OP_NONE;
         eq_ff        <= 1'b0;
         phase_ff     <= kfc_pkg::PHASE_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         op_ff        <= op_in;
         eq_ff        <= eq_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_idle_alu_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !alu_sts.busy)
      else $error("serial ALU busy while taking keys");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      alu_sts.done |-> (state_ff == S_ACC || state_ff == S_CALC))
      else $error("serial ALU finished with no operation waiting");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("phase counter past saturation");

   a_equals_phase: assert property (@(posedge clock) disable iff (reset)
      eq_ff |-> phase_ff != kfc_pkg::PHASE_FIRST)
      else $error("equals flag set in first operand phase");

endmodule

// ===== src/kfc_serial_alu.sv =====
// ----------------------------------------------------------------------------
// kfc_serial_alu
// Bit-serial multiply-accumulate and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module kfc_serial_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  kfc_pkg::alu_cmd_type cmd,
   input  kfc_pkg::operand_type a,
   input  kfc_pkg::operand_type b,
   input  kfc_pkg::operand_type addend,
   output kfc_pkg::alu_sts_type sts,
   output kfc_pkg::operand_type result
);

   localparam int W = kfc_pkg::OPERAND_WIDTH;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 div_ff, div_in;
   kfc_pkg::count_type   cnt_ff, cnt_in;
   kfc_pkg::operand_type mcand_ff, mcand_in;
   kfc_pkg::operand_type mplier_ff, mplier_in;
   kfc_pkg::operand_type acc_ff, acc_in;
   kfc_pkg::operand_type rem_ff, rem_in;
   kfc_pkg::operand_type quo_ff, quo_in;

   logic [W:0]   shifted;
   logic [W+1:0] trial;

   always_comb begin
      shifted   = {rem_ff, quo_ff[W-1]};
      trial     = {1'b0, shifted} - {2'b00, mcand_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         div_in    = cmd.op_div;
         cnt_in    = kfc_pkg::count_type'(W - 1);
         mcand_in  = cmd.op_div ? b : a;
         mplier_in = b;
         acc_in    = addend;
         rem_in    = '0;
         quo_in    = a;
      end else if (busy_ff) begin
         if (div_ff) begin
            quo_in = {quo_ff[W-2:0], ~trial[W+1]};
            rem_in = trial[W+1] ? shifted[W-1:0] : trial[W-1:0];
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[W-1:1]};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - kfc_pkg::count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff    <= div_in;
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = div_ff ? quo_ff : acc_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad calculator. A scripted key sequence
// exercises operand wrap, digits above nine, subtract sign, divide by zero,
// the no-operation and ignored-key cases. Random calculations and key noise
// follow. Results must match scripted words or an in-bench calculator model.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [2:0]  KIND_UNUSED = 3'd7;
   localparam int unsigned RANDOM_KEYS = 600;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic                  typed;
      kfc_pkg::rsp_word_type want;
   } key_note_type;

   typedef struct packed {
      kfc_pkg::req_word_type key;
      logic                  typed;
      kfc_pkg::rsp_word_type want;
   } key_row_type;

   localparam int unsigned SCRIPT_LEN = 26;
   localparam key_row_type KEY_SCRIPT [SCRIPT_LEN] = '{
      '{'{kfc_pkg::KIND_CLEAR,  4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_EQUALS, 4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{KIND_UNUSED,          4'd15}, 1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_CLEAR,  4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd9},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIV,    4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_EQUALS, 4'd0},  1'b1, '{kfc_pkg::STATUS_DIV0, 16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd15}, 1'b1, '{kfc_pkg::STATUS_DIV0, 16'd0}},
      '{'{kfc_pkg::KIND_MUL,    4'd0},  1'b1, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_CLEAR,  4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd6},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd5},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd5},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd3},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd5},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_ADD,    4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd1},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_EQUALS, 4'd0},  1'b1, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_SUB,    4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_CLEAR,  4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd12}, 1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_SUB,    4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_DIGIT,  4'd12}, 1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_EQUALS, 4'd0},  1'b1, '{kfc_pkg::STATUS_NEG,  16'd0}},
      '{'{kfc_pkg::KIND_MUL,    4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}},
      '{'{kfc_pkg::KIND_CLEAR,  4'd0},  1'b0, '{kfc_pkg::STATUS_POS,  16'd0}}
   };

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   kfc_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   kfc_pkg::rsp_word_type rsp_word;

   key_note_type key_note  = '0;
   bit           no_idle   = 1'b0;

   kfc_pkg::operand_type calc_first;
   kfc_pkg::operand_type calc_second;
   logic [2:0]           calc_op;
   logic                 calc_equals;
   logic [1:0]           calc_phase;

   kfc_pkg::rsp_word_type results_due[$];
   int unsigned  idle_cycles   = 0;
   int unsigned  mismatches    = 0;
   int unsigned  keys_sent     = 0;
   int unsigned  results_seen  = 0;
   int unsigned  neg_results   = 0;
   int unsigned  div0_results  = 0;

   keypad_four_function_calculator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void clear_calculator();
      calc_first  = '0;
      calc_second = '0;
      calc_op     = kfc_pkg::OP_NONE;
      calc_equals = 1'b0;
      calc_phase  = kfc_pkg::PHASE_FIRST;
   endfunction

   function automatic bit calculate_key(input kfc_pkg::req_word_type w,
                                        output kfc_pkg::rsp_word_type r);
      kfc_pkg::operand_type                a;
      kfc_pkg::operand_type                b;
      logic [2*kfc_pkg::OPERAND_WIDTH-1:0] wide;
      r = '0;
      if (w.kind == kfc_pkg::KIND_CLEAR) begin
         clear_calculator();
         return 1'b0;
      end
      if (w.kind == KIND_UNUSED) return 1'b0;
      if (w.kind == kfc_pkg::KIND_DIGIT) begin
         if (calc_phase == kfc_pkg::PHASE_FIRST)
            calc_first = calc_first * kfc_pkg::TEN + kfc_pkg::operand_type'(w.digit);
         else if (calc_phase == kfc_pkg::PHASE_SECOND)
            calc_second = calc_second * kfc_pkg::TEN + kfc_pkg::operand_type'(w.digit);
      end else begin
         if (w.kind == kfc_pkg::KIND_EQUALS)
            calc_equals = 1'b1;
         else
            calc_op = w.kind;
         if (calc_phase != kfc_pkg::PHASE_DONE) calc_phase = calc_phase + 2'd1;
      end
      if (!calc_equals || calc_phase == kfc_pkg::PHASE_FIRST || calc_op == kfc_pkg::OP_NONE)
         return 1'b0;
      a = calc_first;
      b = calc_second;
      r.status = kfc_pkg::STATUS_POS;
      case (calc_op)
         kfc_pkg::KIND_ADD: r.value = kfc_pkg::value_type'(kfc_pkg::operand_type'(a + b));
         kfc_pkg::KIND_SUB: begin
            if (a > b) begin
               r.value = kfc_pkg::value_type'(a - b);
            end else begin
               r.status = kfc_pkg::STATUS_NEG;
               r.value  = kfc_pkg::value_type'(b - a);
            end
         end
         kfc_pkg::KIND_MUL: begin
            wide    = a * b;
            r.value = kfc_pkg::value_type'(kfc_pkg::operand_type'(wide));
         end
         default: begin
            if (b != '0) begin
               r.value = kfc_pkg::value_type'(a / b);
            end else begin
               r.status = kfc_pkg::STATUS_DIV0;
               r.value  = '0;
            end
         end
      endcase
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      kfc_pkg::rsp_word_type due;
      kfc_pkg::rsp_word_type calc;
      if (reset) begin
         clear_calculator();
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result word", 0, rsp_word);
            end else begin
               due = results_due.pop_front();
               if (due.status == kfc_pkg::STATUS_NEG)  neg_results++;
               if (due.status == kfc_pkg::STATUS_DIV0) div0_results++;
               if (rsp_word.status !== due.status)
                  report_mismatch("status", due.status, rsp_word.status);
               if (rsp_word.value !== due.value)
                  report_mismatch("value", due.value, rsp_word.value);
            end
         end
         if (req_valid && req_ready) begin
            if (calculate_key(req_word, calc))
               results_due.push_back(key_note.typed ? key_note.want : calc);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
      rsp_ready <= no_idle || ($urandom_range(99) >= 6);
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("[%0t] watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_key(input kfc_pkg::req_word_type w, input key_note_type note);
      if (!no_idle && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!no_idle && $urandom_range(99) < 6);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      key_note  <= note;
      do @(posedge clock); while (!req_ready);
      if (w.kind != KIND_UNUSED) keys_sent++;
   endtask

   task automatic press(input logic [2:0] kind, input logic [3:0] digit);
      send_key(kfc_pkg::req_word_type'{kind, digit}, key_note_type'('0));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_digit();
      if ($urandom_range(9) == 0) return 4'($urandom_range(15, 10));
      return 4'($urandom_range(9));
   endfunction

   task automatic enter_calculation();
      int unsigned count;
      logic [2:0]  op;
      if ($urandom_range(9) != 0) press(kfc_pkg::KIND_CLEAR, 4'($urandom_range(15)));
      count = $urandom_range(5);
      repeat (count) press(kfc_pkg::KIND_DIGIT, pick_digit());
      op = 3'($urandom_range(kfc_pkg::KIND_DIV, kfc_pkg::KIND_ADD));
      press(op, 4'($urandom_range(15)));
      if ($urandom_range(9) == 0)
         press(3'($urandom_range(kfc_pkg::KIND_DIV, kfc_pkg::KIND_ADD)), 4'd0);
      count = $urandom_range(5, (op == kfc_pkg::KIND_DIV) ? 1 : 0);
      repeat (count) press(kfc_pkg::KIND_DIGIT, pick_digit());
      if ($urandom_range(19) != 0) press(kfc_pkg::KIND_EQUALS, 4'($urandom_range(15)));
      count = $urandom_range(3);
      repeat (count)
         press(3'($urandom_range(kfc_pkg::KIND_EQUALS, kfc_pkg::KIND_DIGIT)), pick_digit());
   endtask

   task automatic press_noise();
      int unsigned count;
      count = $urandom_range(6, 1);
      repeat (count) press(3'($urandom_range(7)), 4'($urandom_range(15)));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < SCRIPT_LEN; i++)
         send_key(KEY_SCRIPT[i].key, key_note_type'{KEY_SCRIPT[i].typed, KEY_SCRIPT[i].want});
      drain_results();
      while (keys_sent < SCRIPT_LEN + RANDOM_KEYS) begin
         no_idle <= (keys_sent >= 200) && (keys_sent < 350);
         if ($urandom_range(99) < 15)
            press_noise();
         else
            enter_calculation();
         if ($urandom_range(99) < 5) drain_results();
      end
      drain_results();
      repeat (80) @(posedge clock);
      $display("Pressed %0d keys (scripted and random) with random stalls on both sides.",
               keys_sent);
      $display("Checked %0d result words: %0d negative, %0d divide-by-zero; %0d mismatches.",
               results_seen, neg_results, div0_results, mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
